FILE: hdl/windowed_sinc_kernel_gen_macros.svh
// ----------------------------------------------------------------------------
// windowed_sinc_kernel_gen_macros.svh
// Assertion shorthands for the windowed-sinc kernel generator checkers.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SINC_KERNEL_GEN_MACROS_SVH
`define WINDOWED_SINC_KERNEL_GEN_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wsk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_pkg
// Shared types, widths and constants of the windowed-sinc kernel generator.
// ----------------------------------------------------------------------------
package wsk_pkg;

    // field and datapath widths
    localparam int CUT_W        = 16;
    localparam int KIND_W       = 2;
    localparam int IDX_W        = 6;
    localparam int COEF_W       = 18;
    localparam int PHASE_W      = 32;
    localparam int CW           = 34;   // cordic x/y/z, window, sin/k
    localparam int RAW_W        = 36;   // raw tap, Q.30
    localparam int SUM_W        = 42;   // raw tap sum
    localparam int DEN_W        = 42;   // divider denominator / remainder
    localparam int QUO_W        = 32;   // divider quotient
    localparam int CNT_W        = 6;    // divider step count
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 6;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 1'b1;

    // window kinds (anything else is Hamming)
    localparam logic [KIND_W-1:0] KIND_BLACKMAN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HANNING  = 2'd2;

    // fixed-point constants
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]          TWO_PI_Q29  = 32'd3373259426;
    localparam logic signed [CW-1:0] W_054       = 34'sd579820585;
    localparam logic signed [CW-1:0] W_046       = 34'sd493921239;
    localparam logic signed [CW-1:0] W_042       = 34'sd450971566;
    localparam logic signed [CW-1:0] W_050       = 34'sd536870912;
    localparam logic signed [CW-1:0] W_008       = 34'sd85899346;
    localparam logic [29:0]          HALF_Q30    = 30'd536870912;
    localparam logic [COEF_W-1:0]    COEF_MAX    = 18'h1FFFF;
    localparam logic [COEF_W-1:0]    COEF_MIN    = 18'h20000;
    localparam logic [COEF_W:0]      COEF_MIN_MAG = 19'd131072;

    // step counts per division kind
    localparam logic [CNT_W-1:0] DIV_STEPS_FULL = 6'd32;
    localparam logic [CNT_W-1:0] DIV_STEPS_NORM = 6'd18;

    // arctangent of 2^-n in turns, 2^32 = one turn
    function automatic logic signed [CW-1:0] atan_at(input logic [STEP_W-1:0] n);
        logic signed [CW-1:0] v;
        begin
            unique case (n)
                5'd0:    v = 34'sd536870912;
                5'd1:    v = 34'sd316933406;
                5'd2:    v = 34'sd167458907;
                5'd3:    v = 34'sd85004756;
                5'd4:    v = 34'sd42667331;
                5'd5:    v = 34'sd21354465;
                5'd6:    v = 34'sd10679838;
                5'd7:    v = 34'sd5340245;
                5'd8:    v = 34'sd2670163;
                5'd9:    v = 34'sd1335087;
                5'd10:   v = 34'sd667544;
                5'd11:   v = 34'sd333772;
                5'd12:   v = 34'sd166886;
                5'd13:   v = 34'sd83443;
                5'd14:   v = 34'sd41722;
                5'd15:   v = 34'sd20861;
                5'd16:   v = 34'sd10430;
                5'd17:   v = 34'sd5215;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CENTRE,
        OP_SIN,
        OP_SDIV,
        OP_P1,
        OP_COS1,
        OP_MUL1,
        OP_ACC1,
        OP_COS2,
        OP_MUL2,
        OP_ACC2,
        OP_MULT,
        OP_STORE,
        OP_NDIV,
        OP_EMIT
    } op_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAP,
        ST_SIN_WAIT,
        ST_SDIV_WAIT,
        ST_P1_WAIT,
        ST_C1_WAIT,
        ST_ACC1,
        ST_COS2,
        ST_C2_WAIT,
        ST_ACC2,
        ST_MULT,
        ST_STORE,
        ST_NREAD,
        ST_NDIV,
        ST_NWAIT,
        ST_EMIT
    } state_t;

    // datapath status back to the controller
    typedef struct packed {
        logic cordic_done;
        logic div_done;
        logic is_centre;
        logic is_last;
        logic blackman;
        logic zero_sum;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/wsk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsk_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 63
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wsk_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_cordic
// Iterative rotation CORDIC: sine and cosine of a 32-bit phase, one step
// per cycle, 18 steps.
// ----------------------------------------------------------------------------
module wsk_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [wsk_pkg::PHASE_W-1:0]       phase,
    output logic signed [wsk_pkg::CW-1:0]     sin_q,
    output logic signed [wsk_pkg::CW-1:0]     cos_q,
    output logic                              done
);
    import wsk_pkg::*;

    logic                     busy_reg, busy_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic signed [CW-1:0]     x_reg, x_next;
    logic signed [CW-1:0]     y_reg, y_next;
    logic signed [CW-1:0]     z_reg, z_next;
    logic                     flip_reg, flip_next;

    logic [PHASE_W-1:0]       ph_turn;
    logic [PHASE_W-1:0]       ph_adj;
    logic                     ph_flip;
    logic signed [CW-1:0]     dx, dy, ang;

    // fold the phase into the right half plane
    assign ph_turn = phase + 32'h4000_0000;
    assign ph_flip = ph_turn[PHASE_W-1];
    assign ph_adj  = ph_flip ? (phase - 32'h8000_0000) : phase;

    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;
    assign ang = atan_at(cnt_reg);

    // one micro-rotation per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = {{(CW-PHASE_W){ph_adj[PHASE_W-1]}}, ph_adj};
            flip_next = ph_flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign sin_q = flip_reg ? -y_reg : y_reg;
    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign done  = !busy_reg;

endmodule

FILE: hdl/wsk_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_div
// Restoring unsigned divider, one quotient bit per cycle. The caller loads
// a partial remainder below the divisor and the dividend bits still to come,
// left aligned.
// ----------------------------------------------------------------------------
module wsk_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wsk_pkg::DEN_W-1:0]    rem0,
    input  logic [wsk_pkg::QUO_W-1:0]    low,
    input  logic [wsk_pkg::DEN_W-1:0]    den,
    input  logic [wsk_pkg::CNT_W-1:0]    steps,
    output logic [wsk_pkg::QUO_W-1:0]    quo,
    output logic                         done
);
    import wsk_pkg::*;

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   low_reg, low_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]   den_reg, den_next;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               fits;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // shift-subtract step
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = rem0;
            low_next  = low;
            quo_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next = {low_reg[QUO_W-2:0], 1'b0};
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = !busy_reg;

endmodule

FILE: hdl/wsk_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_datapath
// Tap arithmetic: sinc and window terms, tap scratch store, running sum,
// normalization and the output register.
// ----------------------------------------------------------------------------
module wsk_datapath #(
    parameter int MAX_TAPS = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsk_pkg::op_t                  op,
    output wsk_pkg::sts_t                 sts,
    input  logic [wsk_pkg::CUT_W-1:0]     cutoff,
    input  logic [wsk_pkg::KIND_W-1:0]    window_kind,
    input  logic [wsk_pkg::IDX_W-1:0]     tap_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [wsk_pkg::IDX_W-1:0]     tap_index,
    output logic [wsk_pkg::COEF_W-1:0]    coefficient,
    output logic                          last_tap,
    output logic                          zero_sum
);
    import wsk_pkg::*;

    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int NUM_W  = RAW_W + 16;
    localparam int KV_W   = IDX_W + 1;

    // item and tap registers
    logic [CUT_W-1:0]         cut_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic [IDX_W-1:0]         m_reg;
    logic [IDX_W-1:0]         centre_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [CW-1:0]     sk_reg;
    logic                     sneg_reg;
    logic [PHASE_W-1:0]       p1_reg;
    logic signed [CW-1:0]     win_reg;
    logic signed [RAW_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     nneg_reg;
    logic                     sat_reg;

    // output register
    logic                     ovalid_reg;
    logic [IDX_W-1:0]         oidx_reg;
    logic [COEF_W-1:0]        ocoef_reg;
    logic                     olast_reg;
    logic                     ozero_reg;

    // tap count clamp and centre
    logic [IDX_W-1:0]         m_clamp;
    logic [IDX_W-1:0]         m_less;
    logic [IDX_W-1:0]         m_last;

    always_comb
    begin
        if (tap_count < IDX_W'(2))
        begin
            m_clamp = IDX_W'(2);
        end
        else if (tap_count > IDX_W'(MAX_TAPS))
        begin
            m_clamp = IDX_W'(MAX_TAPS);
        end
        else
        begin
            m_clamp = tap_count;
        end
    end

    assign m_less = m_clamp - 1'b1;
    assign m_last = m_reg - 1'b1;

    // tap offset from the centre
    logic signed [KV_W-1:0]   k;
    logic [IDX_W-1:0]         kabs;
    logic [31:0]              pk;
    logic [PHASE_W-1:0]       ph_sin;

    assign k      = $signed({1'b0, idx_reg}) - $signed({1'b0, centre_reg});
    assign kabs   = k[KV_W-1] ? IDX_W'(-k) : IDX_W'(k);
    assign pk     = cut_reg * {{(CUT_W-KV_W){k[KV_W-1]}}, k};
    assign ph_sin = {pk[15:0], 16'h0000};

    // shared divider
    logic                     div_start;
    logic [DEN_W-1:0]         div_rem0;
    logic [QUO_W-1:0]         div_low;
    logic [DEN_W-1:0]         div_den;
    logic [CNT_W-1:0]         div_steps;
    logic [QUO_W-1:0]         div_quo;
    logic                     div_done;

    // cordic
    logic                     cor_start;
    logic [PHASE_W-1:0]       cor_phase;
    logic signed [CW-1:0]     cor_sin, cor_cos;
    logic                     cor_done;
    logic [CW-1:0]            sabs;

    assign cor_start = (op == OP_SIN) || (op == OP_COS1) || (op == OP_COS2);

    always_comb
    begin
        priority case (op)
            OP_COS1: cor_phase = div_quo;
            OP_COS2: cor_phase = {p1_reg[PHASE_W-2:0], 1'b0};
            default: cor_phase = ph_sin;
        endcase
    end

    assign sabs = cor_sin[CW-1] ? CW'(-cor_sin) : CW'(cor_sin);

    wsk_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .phase (cor_phase),
        .sin_q (cor_sin),
        .cos_q (cor_cos),
        .done  (cor_done)
    );

    // normalization operands
    logic signed [RAW_W-1:0]  raw_rd;
    logic [RAW_W-1:0]         nabs;
    logic [SUM_W-1:0]         dabs;
    logic [NUM_W-1:0]         num;
    logic                     num_sat;

    assign nabs    = raw_rd[RAW_W-1] ? RAW_W'(-raw_rd) : RAW_W'(raw_rd);
    assign dabs    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num     = {nabs, 16'h0000} + NUM_W'(dabs >> 1);
    assign num_sat = {{(SUM_W+18-NUM_W){1'b0}}, num} >= {dabs, 18'h00000};

    assign div_start = (op == OP_SDIV) || (op == OP_P1) || (op == OP_NDIV);

    always_comb
    begin
        priority case (op)
            OP_P1:
            begin
                div_rem0  = (idx_reg == m_last) ? '0 : DEN_W'(idx_reg);
                div_low   = '0;
                div_den   = DEN_W'(m_last);
                div_steps = DIV_STEPS_FULL;
            end
            OP_NDIV:
            begin
                div_rem0  = DEN_W'(num[NUM_W-1:18]);
                div_low   = {num[17:0], 14'h0000};
                div_den   = dabs;
                div_steps = DIV_STEPS_NORM;
            end
            default:
            begin
                div_rem0  = '0;
                div_low   = sabs[QUO_W-1:0];
                div_den   = DEN_W'(kabs);
                div_steps = DIV_STEPS_FULL;
            end
        endcase
    end

    wsk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .rem0  (div_rem0),
        .low   (div_low),
        .den   (div_den),
        .steps (div_steps),
        .quo   (div_quo),
        .done  (div_done)
    );

    // tap scratch store
    logic                     ram_we;
    logic [RAW_W-1:0]         ram_rdata;

    assign ram_we = (op == OP_STORE);
    assign raw_rd = $signed(ram_rdata);

    wsk_ram #(
        .WIDTH (RAW_W),
        .DEPTH (MAX_TAPS)
    ) u_taps (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (prod_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // shared Q.30 multiplier, rounded half up
    logic signed [CW-1:0]     mul_a, mul_b;
    logic signed [2*CW-1:0]   mul_full;
    logic signed [2*CW-1:0]   mul_rnd;
    logic signed [CW-1:0]     w_first, w_base;

    always_comb
    begin
        if (kind_reg == KIND_BLACKMAN)
        begin
            w_first = W_050;
            w_base  = W_042;
        end
        else if (kind_reg == KIND_HANNING)
        begin
            w_first = W_050;
            w_base  = W_050;
        end
        else
        begin
            w_first = W_046;
            w_base  = W_054;
        end
    end

    always_comb
    begin
        priority case (op)
            OP_MUL1:
            begin
                mul_a = w_first;
                mul_b = cor_cos;
            end
            OP_MUL2:
            begin
                mul_a = W_008;
                mul_b = cor_cos;
            end
            default:
            begin
                mul_a = sk_reg;
                mul_b = win_reg;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_rnd  = mul_full + (2*CW)'(HALF_Q30);

    // centre tap: round(cutoff * 2pi * 2^29 / 2^15)
    logic [47:0]              centre_full;
    logic [47:0]              centre_rnd;

    assign centre_full = cut_reg * TWO_PI_Q29;
    assign centre_rnd  = centre_full + 48'd16384;

    // normalized coefficient from the quotient
    logic [COEF_W:0]          q19;
    logic [COEF_W-1:0]        coef;

    assign q19 = div_quo[COEF_W:0];

    always_comb
    begin
        if (sum_reg == '0)
        begin
            coef = '0;
        end
        else if (nneg_reg)
        begin
            if (sat_reg || (div_quo[QUO_W-1:COEF_W+1] != '0) || (q19 > COEF_MIN_MAG))
            begin
                coef = COEF_MIN;
            end
            else
            begin
                coef = COEF_W'(-q19);
            end
        end
        else
        begin
            if (sat_reg || (div_quo[QUO_W-1:COEF_W+1] != '0) || (q19 > {1'b0, COEF_MAX}))
            begin
                coef = COEF_MAX;
            end
            else
            begin
                coef = q19[COEF_W-1:0];
            end
        end
    end

    // operation registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cut_reg    <= cutoff;
                kind_reg   <= window_kind;
                m_reg      <= m_clamp;
                centre_reg <= m_less >> 1;
            end
            OP_CENTRE:
            begin
                prod_reg <= RAW_W'(centre_rnd >> 15);
            end
            OP_SDIV:
            begin
                sneg_reg <= cor_sin[CW-1] ^ k[KV_W-1];
            end
            OP_P1:
            begin
                sk_reg <= sneg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
            end
            OP_COS1:
            begin
                p1_reg <= div_quo;
            end
            OP_MUL1, OP_MUL2, OP_MULT:
            begin
                prod_reg <= mul_rnd[RAW_W+29:30];
            end
            OP_ACC1:
            begin
                win_reg <= w_base - CW'(prod_reg);
            end
            OP_ACC2:
            begin
                win_reg <= win_reg + CW'(prod_reg);
            end
            OP_NDIV:
            begin
                nneg_reg <= raw_rd[RAW_W-1] ^ sum_reg[SUM_W-1];
                sat_reg  <= num_sat;
            end
            OP_NONE, OP_SIN, OP_COS2, OP_STORE, OP_EMIT:
            begin
            end
        endcase
    end

    // tap index and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (op == OP_LOAD)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (op == OP_STORE)
        begin
            idx_reg <= (idx_reg == m_last) ? '0 : idx_reg + 1'b1;
            sum_reg <= sum_reg + {{(SUM_W-RAW_W){prod_reg[RAW_W-1]}}, prod_reg};
        end
        else if (op == OP_EMIT)
        begin
            idx_reg <= (idx_reg == m_last) ? '0 : idx_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (op == OP_EMIT)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_EMIT)
        begin
            oidx_reg  <= idx_reg;
            ocoef_reg <= coef;
            olast_reg <= (idx_reg == m_last);
            ozero_reg <= (sum_reg == '0);
        end
    end

    assign out_valid   = ovalid_reg;
    assign tap_index   = oidx_reg;
    assign coefficient = ocoef_reg;
    assign last_tap    = olast_reg;
    assign zero_sum    = ozero_reg;

    // status
    assign sts.cordic_done = cor_done;
    assign sts.div_done    = div_done;
    assign sts.is_centre   = (idx_reg == centre_reg);
    assign sts.is_last     = (idx_reg == m_last);
    assign sts.blackman    = (kind_reg == KIND_BLACKMAN);
    assign sts.zero_sum    = (sum_reg == '0);
    assign sts.out_free    = !ovalid_reg || out_ready;

endmodule

FILE: hdl/wsk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_ctrl
// Sequencer: builds every raw tap, then normalizes and emits them in order.
// ----------------------------------------------------------------------------
module wsk_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wsk_pkg::sts_t  sts,
    output wsk_pkg::op_t   op
);
    import wsk_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (sts.is_centre)
                begin
                    op         = OP_CENTRE;
                    state_next = ST_STORE;
                end
                else
                begin
                    op         = OP_SIN;
                    state_next = ST_SIN_WAIT;
                end
            end
            ST_SIN_WAIT:
            begin
                if (sts.cordic_done)
                begin
                    op         = OP_SDIV;
                    state_next = ST_SDIV_WAIT;
                end
            end
            ST_SDIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    op         = OP_P1;
                    state_next = ST_P1_WAIT;
                end
            end
            ST_P1_WAIT:
            begin
                if (sts.div_done)
                begin
                    op         = OP_COS1;
                    state_next = ST_C1_WAIT;
                end
            end
            ST_C1_WAIT:
            begin
                if (sts.cordic_done)
                begin
                    op         = OP_MUL1;
                    state_next = ST_ACC1;
                end
            end
            ST_ACC1:
            begin
                op         = OP_ACC1;
                state_next = sts.blackman ? ST_COS2 : ST_MULT;
            end
            ST_COS2:
            begin
                op         = OP_COS2;
                state_next = ST_C2_WAIT;
            end
            ST_C2_WAIT:
            begin
                if (sts.cordic_done)
                begin
                    op         = OP_MUL2;
                    state_next = ST_ACC2;
                end
            end
            ST_ACC2:
            begin
                op         = OP_ACC2;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                op         = OP_MULT;
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                op         = OP_STORE;
                state_next = sts.is_last ? ST_NREAD : ST_TAP;
            end
            ST_NREAD:
            begin
                // store read of the current tap is issued here; its data is ready in ST_NDIV
                state_next = ST_NDIV;
            end
            ST_NDIV:
            begin
                op         = OP_NDIV;
                state_next = sts.zero_sum ? ST_EMIT : ST_NWAIT;
            end
            ST_NWAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = sts.is_last ? ST_IDLE : ST_NREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/windowed_sinc_kernel_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sinc_kernel_gen
// Windowed-sinc low-pass FIR kernel generator (Hamming, Blackman, Hanning).
// ----------------------------------------------------------------------------
// Usage:
//   One transfer on the s_ channel carries a cutoff (Q0.16 of the sample
//   rate). The block answers with tap_count (clamped to 2..MAX_TAPS) transfers on the m_ channel, one
//   per tap in index order, coefficients in signed Q1.16, normalized to unit
//   sum; tlast marks the final tap, tuser flags a kernel whose raw sum was 0.
//   window_kind and tap_count are written over the cfg_ port while idle.
// Sequence:
//   Build pass per off-centre tap: 18-step CORDIC, two 32-step divisions and
//   a second CORDIC (a third for Blackman); the centre tap uses neither unit.
//   Normalize pass: one 18-step division per tap.
//   Both passes share one divider and one CORDIC unit.
// Reset and stall:
//   Reset returns to idle with Hamming and 31 taps. When m_tready is low the
//   sequencer holds at the next tap until the output register frees up; a
//   new cutoff is taken once the last tap sits in the output register.
// ----------------------------------------------------------------------------
module windowed_sinc_kernel_gen #(
    parameter int MAX_TAPS = 63
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [15:0] cutoff
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,   // [5:0] tap_index, [23:6] coefficient
    output logic                                 m_tlast,   // last_tap
    output logic                                 m_tuser,   // zero_sum
    input  logic                                 cfg_we,
    input  logic [wsk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wsk_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import wsk_pkg::*;

    logic [KIND_W-1:0]  window_kind_reg;
    logic [IDX_W-1:0]   tap_count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_kind_reg <= '0;
            tap_count_reg   <= IDX_W'(31);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WINDOW_KIND)
            begin
                window_kind_reg <= cfg_data[KIND_W-1:0];
            end
            else if (cfg_index == REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg_data[IDX_W-1:0];
            end
        end
    end

    op_t                op;
    sts_t               sts;
    logic [IDX_W-1:0]   tap_index;
    logic [COEF_W-1:0]  coefficient;

    wsk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .op       (op)
    );

    wsk_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .sts         (sts),
        .cutoff      (s_tdata[CUT_W-1:0]),
        .window_kind (window_kind_reg),
        .tap_count   (tap_count_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .tap_index   (tap_index),
        .coefficient (coefficient),
        .last_tap    (m_tlast),
        .zero_sum    (m_tuser)
    );

    assign m_tdata = {coefficient, tap_index};

endmodule

FILE: hdl/wsk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsk_checker
// Port-level checks on the kernel generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "windowed_sinc_kernel_gen_macros.svh"

module wsk_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [15:0]                      s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [23:0]                      m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser,
    input logic                             cfg_we,
    input logic [wsk_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [wsk_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // a taken cutoff deasserts the input ready
    `WSK_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input still ready after transfer")

    // stalled tap holds
    `WSK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled tap changed")

    // zero-sum kernels carry zero coefficients
    `WSK_ASSERT_NOW(a_zero_coef, m_tvalid && m_tuser, m_tdata[23:6] == 18'd0, "flagged tap not zero")

    // every kernel has at least two taps
    `WSK_ASSERT_NOW(a_first_not_last, m_tvalid && (m_tdata[5:0] == 6'd0), !m_tlast, "tap 0 marked last")

endmodule

bind windowed_sinc_kernel_gen wsk_checker u_wsk_checker (.*);
